/* hw/rtl/sssc_pkg.sv */
// ----------------------------------------------------------------------------
// sssc_pkg: shared definitions of the shell statement completeness scanner
// Default sizes, the character codes that the scanner reacts to, and the
// encoding of the pending '<' tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package sssc_pkg;

  // Default sizes of the delimiter capture and of the brace counter.
  localparam int unsigned WORD_CAP_DEF  = 64;
  localparam int unsigned BRACE_MAX_DEF = 255;

  // Character codes.
  localparam logic [7:0] CH_LT     = 8'h3C;  // '<'
  localparam logic [7:0] CH_LBRACE = 8'h7B;  // '{'
  localparam logic [7:0] CH_RBRACE = 8'h7D;  // '}'
  localparam logic [7:0] CH_DOLLAR = 8'h24;  // '$'
  localparam logic [7:0] CH_SQUOTE = 8'h27;  // single quote
  localparam logic [7:0] CH_DQUOTE = 8'h22;  // double quote
  localparam logic [7:0] CH_BSLASH = 8'h5C;  // backslash
  localparam logic [7:0] CH_NL     = 8'h0A;  // newline
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // Number of '<' seen in a row outside quotes, waiting for the next byte.
  typedef enum logic [1:0] {
    LT_NONE = 2'd0,
    LT_ONE  = 2'd1,
    LT_TWO  = 2'd2
  } lt_t;

endpackage

`default_nettype wire

/* hw/rtl/sssc_ram.sv */
// ----------------------------------------------------------------------------
// sssc_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sssc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 63,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/shell_statement_completeness_scanner_unit.sv */
// ----------------------------------------------------------------------------
// shell_statement_completeness_scanner_unit: streaming shell completeness test
//
// Text enters one byte per transaction on the input channel (ch, first under
// in_valid/in_ready). Every input transaction yields exactly one output
// transaction (complete, depth under out_valid/out_ready) telling whether the
// text through that byte forms a complete statement, and the open brace
// count outside quotes, shown saturated at 255.
// Setting first on a byte clears all scan state before that byte is taken.
// The result is held in an output register the cycle after the byte is
// accepted. Throughput is one byte per cycle while the receiver is ready;
// the input is taken in the same cycle the pending result leaves, so a
// steady stream with an always-ready receiver never pauses. The only state
// read that sits in a memory is one delimiter byte per heredoc body byte;
// its read address comes from the next line length, so it never stalls.
// When the receiver holds out_ready low, the result stays put and in_ready
// drops until it is taken; no byte is lost. Synchronous reset clears the scan
// flags, counters and the output valid; the delimiter RAM needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_statement_completeness_scanner_unit #(
  parameter int unsigned WORD_CAP  = sssc_pkg::WORD_CAP_DEF,
  parameter int unsigned BRACE_MAX = sssc_pkg::BRACE_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] ch,
  input  wire logic       first,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            complete,
  output logic [7:0]      depth
);

  // Delimiter store holds WORD_CAP-1 bytes; counters must reach WORD_CAP-1.
  localparam int unsigned RAM_DEPTH = WORD_CAP - 1;
  localparam int unsigned AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int unsigned LW = $clog2(WORD_CAP);
  localparam int unsigned BW = $clog2(BRACE_MAX + 1);

  // Scan state registers.
  logic            single_quoted, single_quoted_next;
  logic            double_quoted, double_quoted_next;
  logic            escape_pending, escape_pending_next;
  sssc_pkg::lt_t   less_than_seen, less_than_seen_next;
  logic            want_word, want_word_next;
  logic            in_body, in_body_next;
  logic [BW-1:0]   brace_count, brace_count_next;
  logic [LW-1:0]   word_length, word_length_next;
  logic [LW-1:0]   line_length, line_length_next;
  logic            line_matches, line_matches_next;

  logic            accept;
  logic            do_word;
  logic            store_we;
  logic [7:0]      store_rdata;
  logic            complete_next;
  logic [16:0]     brace_wide;

  // The output register frees up in the same cycle it is drained.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // Next scan state for the byte on the input. Applying first here means the
  // cleared state is what the byte sees. The delimiter byte on store_rdata is
  // the entry at the current line_length, since the read address below always
  // follows the line length the registers will hold next.
  always_comb begin
    single_quoted_next  = first ? 1'b0 : single_quoted;
    double_quoted_next  = first ? 1'b0 : double_quoted;
    escape_pending_next = first ? 1'b0 : escape_pending;
    less_than_seen_next = first ? sssc_pkg::LT_NONE : less_than_seen;
    want_word_next      = first ? 1'b0 : want_word;
    in_body_next        = first ? 1'b0 : in_body;
    brace_count_next    = first ? '0 : brace_count;
    word_length_next    = first ? '0 : word_length;
    line_length_next    = first ? '0 : line_length;
    line_matches_next   = first ? 1'b1 : line_matches;
    do_word             = 1'b0;
    store_we            = 1'b0;

    if (in_body_next) begin
      // Heredoc body: compare the line against the captured delimiter.
      if (ch == sssc_pkg::CH_NL) begin
        if (line_matches_next && line_length_next == word_length_next) begin
          in_body_next     = 1'b0;
          word_length_next = '0;
        end
        line_length_next  = '0;
        line_matches_next = 1'b1;
      end else if (line_length_next < LW'(WORD_CAP - 1)) begin
        if (line_length_next >= word_length_next || store_rdata != ch) begin
          line_matches_next = 1'b0;
        end
        line_length_next = line_length_next + LW'(1);
      end
    end else if (want_word_next) begin
      do_word = 1'b1;
    end else if (single_quoted_next) begin
      if (ch == sssc_pkg::CH_SQUOTE) begin
        single_quoted_next = 1'b0;
      end
    end else if (double_quoted_next) begin
      if (escape_pending_next) begin
        escape_pending_next = 1'b0;
        if (ch == sssc_pkg::CH_DQUOTE || ch == sssc_pkg::CH_BSLASH ||
            ch == sssc_pkg::CH_DOLLAR) begin
          // Escaped byte: consumed with no further effect.
        end else if (ch == sssc_pkg::CH_DQUOTE) begin
          double_quoted_next = 1'b0;
        end
      end else if (ch == sssc_pkg::CH_BSLASH) begin
        escape_pending_next = 1'b1;
      end else if (ch == sssc_pkg::CH_DQUOTE) begin
        double_quoted_next = 1'b0;
      end
    end else if (less_than_seen_next == sssc_pkg::LT_TWO) begin
      // Third '<' makes a herestring; anything else starts the delimiter.
      less_than_seen_next = sssc_pkg::LT_NONE;
      if (ch != sssc_pkg::CH_LT) begin
        want_word_next   = 1'b1;
        word_length_next = '0;
        do_word          = 1'b1;
      end
    end else if (less_than_seen_next == sssc_pkg::LT_ONE && ch == sssc_pkg::CH_LT) begin
      less_than_seen_next = sssc_pkg::LT_TWO;
    end else begin
      less_than_seen_next = sssc_pkg::LT_NONE;
      case (ch)
        sssc_pkg::CH_SQUOTE: single_quoted_next  = 1'b1;
        sssc_pkg::CH_DQUOTE: double_quoted_next  = 1'b1;
        sssc_pkg::CH_LT:     less_than_seen_next = sssc_pkg::LT_ONE;
        sssc_pkg::CH_NL: begin
          if (word_length_next != '0) begin
            in_body_next      = 1'b1;
            line_length_next  = '0;
            line_matches_next = 1'b1;
          end
        end
        sssc_pkg::CH_LBRACE: begin
          if (brace_count_next < BW'(BRACE_MAX)) begin
            brace_count_next = brace_count_next + BW'(1);
          end
        end
        sssc_pkg::CH_RBRACE: begin
          if (brace_count_next != '0) begin
            brace_count_next = brace_count_next - BW'(1);
          end
        end
        default: begin
        end
      endcase
    end

    // Delimiter capture, shared by the word state and the byte after "<<".
    if (do_word) begin
      if (ch == sssc_pkg::CH_SPACE || ch == sssc_pkg::CH_TAB) begin
        if (word_length_next != '0) begin
          want_word_next = 1'b0;
        end
      end else if (ch == sssc_pkg::CH_NL) begin
        if (word_length_next != '0) begin
          want_word_next    = 1'b0;
          in_body_next      = 1'b1;
          line_length_next  = '0;
          line_matches_next = 1'b1;
        end
      end else if (word_length_next < LW'(WORD_CAP - 1)) begin
        store_we         = 1'b1;
        word_length_next = word_length_next + LW'(1);
      end
    end

    complete_next = !single_quoted_next && !double_quoted_next &&
                    brace_count_next == '0 && !want_word_next && !in_body_next &&
                    less_than_seen_next != sssc_pkg::LT_TWO;
  end

  // Saturate the displayed depth at 255 for counter widths up to 17 bits.
  assign brace_wide = 17'(brace_count_next);

  // Delimiter store. A write happens only while a word is being captured and
  // the body that reads it opens no earlier than the next byte, so a write
  // and a read of the same entry never overlap in a way that matters. The
  // write address is the pre-increment word length.
  logic [LW-1:0] store_waddr;
  assign store_waddr = word_length_next - LW'(1);

  sssc_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (accept && store_we),
    .waddr (store_waddr[AW-1:0]),
    .wdata (ch),
    .raddr (accept ? line_length_next[AW-1:0] : line_length[AW-1:0]),
    .rdata (store_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      single_quoted  <= 1'b0;
      double_quoted  <= 1'b0;
      escape_pending <= 1'b0;
      less_than_seen <= sssc_pkg::LT_NONE;
      want_word      <= 1'b0;
      in_body        <= 1'b0;
      brace_count    <= '0;
      word_length    <= '0;
      line_length    <= '0;
      line_matches   <= 1'b1;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        single_quoted  <= single_quoted_next;
        double_quoted  <= double_quoted_next;
        escape_pending <= escape_pending_next;
        less_than_seen <= less_than_seen_next;
        want_word      <= want_word_next;
        in_body        <= in_body_next;
        brace_count    <= brace_count_next;
        word_length    <= word_length_next;
        line_length    <= line_length_next;
        line_matches   <= line_matches_next;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; loaded only when a byte is taken.
  always_ff @(posedge clk) begin
    if (accept) begin
      complete <= complete_next;
      depth    <= (brace_wide > 17'd255) ? 8'hFF : brace_wide[7:0];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/sssc_checker.sv */
// ----------------------------------------------------------------------------
// sssc_checker: port-level checks of the completeness scanner
// Watches the top-level ports and flags broken transaction ordering or
// inconsistent results.
// ----------------------------------------------------------------------------
`default_nettype none

module sssc_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [7:0] ch,
  input wire logic       first,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       complete,
  input wire logic [7:0] depth
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(complete) && $stable(depth))
    else $error("result changed while stalled");

  // Every accepted byte shows a result in the next cycle.
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted byte produced no result");

  // No new byte is taken while an untaken result would be overwritten.
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken over a stalled result");

  // A complete statement has no open braces.
  a_complete_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && complete |-> depth == 8'd0)
    else $error("complete reported with open braces");

  // An opening brace on a fresh buffer leaves exactly one open brace.
  a_first_brace: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && first && ch == sssc_pkg::CH_LBRACE |=>
      depth == 8'd1 && !complete)
    else $error("fresh buffer brace count wrong");

endmodule

bind shell_statement_completeness_scanner_unit sssc_checker u_sssc_checker (.*);

`default_nettype wire

/* tb/sv/sssc_tb_pkg.sv */
// ----------------------------------------------------------------------------
// sssc_tb_pkg: statement tracker for the completeness scanner testbench
// Holds a bit-true software copy of the scan state. Each accepted byte is
// stepped through it to predict one verdict, and the verdicts that the block
// returns are compared against that prediction in order.
// ----------------------------------------------------------------------------
package sssc_tb_pkg;

  import sssc_pkg::*;

  // Longest delimiter that is kept, and longest body prefix that is compared.
  localparam int unsigned DELIM_MAX = WORD_CAP_DEF - 1;

  // Only this many mismatch lines are printed, although all are counted.
  localparam int unsigned MAX_PRINTED = 30;

  typedef struct packed {
    logic       complete;
    logic [7:0] depth;
  } verdict_t;

  class statement_tracker;

    bit          squote_open;
    bit          dquote_open;
    bit          esc_wait;
    bit          awaiting_delim;
    bit          in_heredoc;
    bit          body_ok;
    lt_t         lt_run;
    int unsigned braces;
    int unsigned delim_len;
    int unsigned body_col;
    logic [7:0]  delim [DELIM_MAX];

    verdict_t    expected_verdicts [$];
    int unsigned mismatches;
    int unsigned verdicts_seen;

    function new();
      clear();
      mismatches    = 0;
      verdicts_seen = 0;
    endfunction

    function void clear();
      squote_open    = 1'b0;
      dquote_open    = 1'b0;
      esc_wait       = 1'b0;
      awaiting_delim = 1'b0;
      in_heredoc     = 1'b0;
      body_ok        = 1'b1;
      lt_run         = LT_NONE;
      braces         = 0;
      delim_len      = 0;
      body_col       = 0;
      foreach (delim[i]) delim[i] = 8'h00;
    endfunction

    function void start_body();
      in_heredoc = 1'b1;
      body_col   = 0;
      body_ok    = 1'b1;
    endfunction

    // A byte inside the heredoc body. A newline closes the line and ends the
    // body when the whole line equaled the delimiter.
    function void heredoc_byte(logic [7:0] c);
      if (c == CH_NL) begin
        if (body_ok && body_col == delim_len) begin
          in_heredoc = 1'b0;
          delim_len  = 0;
        end
        body_col = 0;
        body_ok  = 1'b1;
      end else if (body_col < DELIM_MAX) begin
        if (body_col >= delim_len || delim[body_col] != c) body_ok = 1'b0;
        body_col++;
      end
    endfunction

    function void delim_byte(logic [7:0] c);
      if (c == CH_SPACE || c == CH_TAB) begin
        if (delim_len > 0) awaiting_delim = 1'b0;
      end else if (c == CH_NL) begin
        if (delim_len > 0) begin
          awaiting_delim = 1'b0;
          start_body();
        end
      end else if (delim_len < DELIM_MAX) begin
        delim[delim_len] = c;
        delim_len++;
      end
    endfunction

    function void unquoted_byte(logic [7:0] c);
      if (lt_run == LT_TWO) begin
        lt_run = LT_NONE;
        if (c != CH_LT) begin
          awaiting_delim = 1'b1;
          delim_len      = 0;
          delim_byte(c);
        end
        return;
      end
      if (lt_run == LT_ONE) begin
        if (c == CH_LT) begin
          lt_run = LT_TWO;
          return;
        end
        lt_run = LT_NONE;
      end
      case (c)
        CH_SQUOTE: squote_open = 1'b1;
        CH_DQUOTE: dquote_open = 1'b1;
        CH_LT:     lt_run = LT_ONE;
        CH_NL:     if (delim_len > 0) start_body();
        CH_LBRACE: if (braces < BRACE_MAX_DEF) braces++;
        CH_RBRACE: if (braces > 0) braces--;
        default: ;
      endcase
    endfunction

    // Steps the scan state by one accepted byte and queues its verdict.
    function void note_byte(logic [7:0] c, logic fresh);
      verdict_t v;
      bit       swallowed;
      if (fresh) clear();
      if (in_heredoc) begin
        heredoc_byte(c);
      end else if (awaiting_delim) begin
        delim_byte(c);
      end else if (squote_open) begin
        if (c == CH_SQUOTE) squote_open = 1'b0;
      end else if (dquote_open) begin
        swallowed = 1'b0;
        if (esc_wait) begin
          esc_wait = 1'b0;
          if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_DOLLAR) swallowed = 1'b1;
        end
        if (!swallowed) begin
          if (c == CH_BSLASH) esc_wait = 1'b1;
          else if (c == CH_DQUOTE) dquote_open = 1'b0;
        end
      end else begin
        unquoted_byte(c);
      end
      v.complete = !squote_open && !dquote_open && braces == 0 && !awaiting_delim &&
                   !in_heredoc && lt_run != LT_TWO;
      v.depth    = (braces > 255) ? 8'hFF : braces[7:0];
      expected_verdicts.push_back(v);
    endfunction

    task report_mismatch(string what);
      if (mismatches < MAX_PRINTED) $display("MISMATCH at verdict %0d: %s", verdicts_seen, what);
      mismatches++;
    endtask

    task check_verdict(logic got_complete, logic [7:0] got_depth);
      verdict_t want;
      if (expected_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result complete=%0b depth=%0d",
                                  got_complete, got_depth));
      end else begin
        want = expected_verdicts.pop_front();
        if (got_complete !== want.complete)
          report_mismatch($sformatf("complete got %0b want %0b", got_complete, want.complete));
        if (got_depth !== want.depth)
          report_mismatch($sformatf("depth got %0d want %0d", got_depth, want.depth));
      end
      verdicts_seen++;
    endtask

  endclass

endpackage

/* tb/sv/shell_statement_completeness_scanner_unit_test.sv */
// ----------------------------------------------------------------------------
// shell_statement_completeness_scanner_unit_test: top-level testbench
// Streams shell text into the scanner one byte per transaction and checks the
// verdict of every byte against the statement tracker. A short directed run
// hits quotes, escapes, stray braces, herestrings and a small heredoc; long
// sequences cover brace saturation and oversized delimiters and body lines;
// the random run builds shell-like fragments under four idling mixes and one
// long receiver hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module shell_statement_completeness_scanner_unit_test;

  timeunit 1ns;
  timeprecision 1ps;

  import sssc_pkg::*;
  import sssc_tb_pkg::*;

  // Generous bound on the whole run; the slowest legal run needs far fewer.
  localparam int unsigned CYCLE_LIMIT = 200000;
  // Items per random idling phase.
  localparam int unsigned PHASE_BYTES = 30;
  // Cycles to linger after the last verdict.
  localparam int unsigned DRAIN_CYCLES = 8;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] ch        = 8'h01;
  logic       first     = 1'b0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       complete;
  logic [7:0] depth;

  statement_tracker sb;

  // Idling mix. The sender skips a cycle with probability idle_pct percent,
  // the receiver stalls a cycle with probability stall_pct percent, and
  // hold_left forces a stretch of consecutive receiver stalls.
  int unsigned idle_pct   = 0;
  int unsigned stall_pct  = 0;
  int unsigned hold_left  = 0;
  int unsigned bytes_sent = 0;
  int unsigned cycle_count = 0;

  // Text of the fragment being built before it is streamed out.
  logic [7:0] text_q [$];

  shell_statement_completeness_scanner_unit dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .ch        (ch),
    .first     (first),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .complete  (complete),
    .depth     (depth)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver. The forced hold-off is counted down here, one cycle at a time,
  // independent of what the sender is doing.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // Monitor. Both channels are sampled at the clock edge, before any of this
  // edge's updates land, so the values seen are the ones the block acted on.
  // An input and an output transaction on the same edge are independent: the
  // output belongs to an earlier byte that is already queued.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_byte(ch, first);
      if (out_valid && out_ready) sb.check_verdict(complete, depth);
    end
  end

  // Offers one byte, with random idle cycles ahead of it, and returns on the
  // edge at which the transaction completes.
  task automatic send_byte(input logic [7:0] c, input logic fresh);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    first    <= fresh;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input logic fresh);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], fresh && i == 0);
  endtask

  // Streams the built fragment; a fresh fragment starts a new buffer.
  task automatic send_fragment(input logic fresh);
    foreach (text_q[i]) send_byte(text_q[i], fresh && i == 0);
    text_q.delete();
  endtask

  function automatic logic [7:0] rand_letter();
    return 8'h61 + 8'($urandom_range(25));
  endfunction

  // Any byte but NUL, leaning on the ones the scanner reacts to.
  function automatic logic [7:0] rand_noise_byte();
    if ($urandom_range(1)) return 8'($urandom_range(1, 255));
    case ($urandom_range(9))
      0: return CH_LT;
      1: return CH_LBRACE;
      2: return CH_RBRACE;
      3: return CH_SQUOTE;
      4: return CH_DQUOTE;
      5: return CH_BSLASH;
      6: return CH_DOLLAR;
      7: return CH_NL;
      8: return CH_SPACE;
      default: return CH_TAB;
    endcase
  endfunction

  // A delimiter byte: no blank and no newline, but otherwise anything.
  function automatic logic [7:0] rand_word_byte();
    logic [7:0] b;
    if ($urandom_range(3) != 0) return rand_letter();
    do b = 8'($urandom_range(1, 255)); while (b == CH_SPACE || b == CH_TAB || b == CH_NL);
    return b;
  endfunction

  function automatic logic [7:0] rand_line_byte();
    logic [7:0] b;
    do b = rand_noise_byte(); while (b == CH_NL);
    return b;
  endfunction

  // Builds "<<word", an optional tail, a few body lines and, most of the time,
  // the terminating line. Body lines are chosen to nearly match the word.
  function automatic void add_heredoc();
    logic [7:0] w [$];
    int unsigned n;
    int unsigned pos;
    n = $urandom_range(1, 6);
    repeat (n) w.push_back(rand_word_byte());
    text_q.push_back(CH_LT);
    text_q.push_back(CH_LT);
    repeat ($urandom_range(0, 2)) text_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
    text_q = {text_q, w};
    if ($urandom_range(2) == 0) begin
      text_q.push_back(CH_SPACE);
      text_q.push_back(rand_letter());
    end
    text_q.push_back(CH_NL);
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(4))
        0: for (int i = 0; i + 1 < w.size(); i++) text_q.push_back(w[i]);
        1: begin
          text_q = {text_q, w};
          text_q.push_back(rand_letter());
        end
        2: repeat ($urandom_range(0, 5)) text_q.push_back(rand_line_byte());
        3: ;
        default: begin
          pos = $urandom_range(w.size() - 1);
          foreach (w[i]) text_q.push_back(i == pos ? (w[i] == 8'h71 ? 8'h72 : 8'h71) : w[i]);
        end
      endcase
      text_q.push_back(CH_NL);
    end
    if ($urandom_range(9) != 0) begin
      text_q = {text_q, w};
      text_q.push_back(CH_NL);
    end
  endfunction

  // A group of nested braces with short words inside, usually balanced.
  function automatic void n_braces_open();
    int unsigned levels;
    levels = $urandom_range(1, 3);
    repeat (levels) text_q = {text_q, CH_LBRACE, CH_SPACE, rand_letter(), CH_NL};
    repeat (levels - ($urandom_range(4) == 0 ? 1 : 0)) text_q = {text_q, CH_RBRACE, CH_NL};
  endfunction

  // Picks one shell-like fragment. Most are well-formed; the noise and the
  // occasional missing closer keep the broken paths busy as well.
  function automatic void build_fragment();
    case ($urandom_range(11))
      0, 1: repeat ($urandom_range(1, 8)) text_q.push_back(rand_noise_byte());
      2: begin
        repeat ($urandom_range(1, 6)) text_q.push_back(rand_letter());
        text_q.push_back($urandom_range(1) ? CH_SPACE : CH_NL);
      end
      3: begin
        text_q.push_back(CH_SQUOTE);
        repeat ($urandom_range(0, 5)) begin
          logic [7:0] b;
          do b = rand_noise_byte(); while (b == CH_SQUOTE);
          text_q.push_back(b);
        end
        if ($urandom_range(9) != 0) text_q.push_back(CH_SQUOTE);
      end
      4: begin
        text_q.push_back(CH_DQUOTE);
        repeat ($urandom_range(0, 5)) begin
          case ($urandom_range(7))
            0: text_q.push_back(rand_letter());
            1: text_q = {text_q, CH_BSLASH, CH_DQUOTE};
            2: text_q = {text_q, CH_BSLASH, CH_BSLASH};
            3: text_q = {text_q, CH_BSLASH, CH_DOLLAR};
            4: text_q = {text_q, CH_BSLASH, rand_letter()};
            5: text_q.push_back(CH_DOLLAR);
            6: text_q.push_back(CH_SQUOTE);
            default: text_q.push_back(CH_NL);
          endcase
        end
        if ($urandom_range(9) != 0) text_q.push_back(CH_DQUOTE);
      end
      5: begin
        n_braces_open();
      end
      6, 7, 8: add_heredoc();
      9: begin
        text_q = {text_q, CH_LT, CH_LT, CH_LT};
        repeat ($urandom_range(1, 4)) text_q.push_back(rand_word_byte());
        text_q.push_back(CH_NL);
      end
      10: text_q.push_back(CH_NL);
      default: text_q = {text_q, CH_LT, rand_letter()};
    endcase
  endfunction

  initial begin
    logic [7:0] w [$];
    int unsigned phase_start;

    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part: extreme byte values, a stray closing brace, both quote
    // kinds, every escape plus a non-escapable one, a herestring whose "<<"
    // leaves the text incomplete for a byte, and a small heredoc.
    send_byte(8'h01, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_text("}{}", 1'b0);
    send_text("''", 1'b0);
    send_text("\"\\\"\\\\\\q\\$\"", 1'b0);
    send_text("<<<", 1'b0);
    send_text("<<E\nE\n", 1'b0);

    // Oversized delimiter: only its first bytes are kept. A body line that
    // differs inside that prefix keeps the body open; a line as long as the
    // delimiter matches, since the tail beyond the prefix is ignored.
    repeat (DELIM_MAX + 3) w.push_back(rand_letter());
    text_q = {CH_LT, CH_LT, w, CH_NL};
    for (int i = 0; i < w.size(); i++) text_q.push_back(i == 5 ? CH_DOLLAR : w[i]);
    text_q = {text_q, CH_NL, w, CH_NL};
    send_fragment(1'b1);

    // Brace saturation, then a few closing braces back down from the ceiling.
    repeat (BRACE_MAX_DEF + 3) text_q.push_back(CH_LBRACE);
    repeat (3) text_q.push_back(CH_RBRACE);
    send_fragment(1'b1);

    // Random part in four idling mixes. Right after the mix without idling,
    // the receiver holds off for a long stretch while the sender keeps
    // offering, so the output register fills and the input stalls.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_fragment();
        send_fragment($urandom_range(9) == 0);
      end
      if (phase == 0) begin
        hold_left = 60;
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < 16) begin
          build_fragment();
          send_fragment(1'b0);
        end
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);

    // Drain: every outstanding verdict must come back, then a few quiet
    // cycles catch any result that should not be there.
    while (sb.expected_verdicts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.expected_verdicts.size() != 0) sb.report_mismatch("verdicts never returned");

    if (sb.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
